FILE: sv/svs_pkg.sv
// ----------------------------------------------------------------------------
// svs_pkg: shared types and constants of the viscosity switch update
// Payload layout, register indexes and reset values, and the record that
// travels down the divider cell chain.
// ----------------------------------------------------------------------------
package svs_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned QUO_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;

  // Widths of the wide intermediates: numerator below 2^129, divisor below 2^97.
  localparam int unsigned NUM_W = 129;
  localparam int unsigned DEN_W = 97;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_CONSTANT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_FLOOR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_CEILING  = 3'd3;

  localparam logic [DATA_W-1:0] RST_TIME_STEP      = 32'd0;
  localparam logic [DATA_W-1:0] RST_DECAY_CONSTANT = 32'd6554;
  localparam logic [DATA_W-1:0] RST_COEFF_FLOOR    = 32'd6554;
  localparam logic [DATA_W-1:0] RST_COEFF_CEILING  = 32'd65536;

  typedef struct packed {
    logic [DATA_W-1:0]        sound_speed;
    logic [DATA_W-1:0]        smoothing_length;
    logic [DATA_W-1:0]        old_coeff;
    logic signed [DATA_W-1:0] velocity_divergence;
  } in_t;

  // One division in progress: partial remainder, divisor, quotient bits so far.
  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] quo;
    logic             sat;
  } div_t;

endpackage

FILE: sv/svs_if.sv
// ----------------------------------------------------------------------------
// svs_if: stream channels of the viscosity switch update
// Valid/ready channels for particle items and for updated coefficients.
// ----------------------------------------------------------------------------
interface svs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sound_speed;
  logic [31:0] smoothing_length;
  logic [31:0] old_coeff;
  logic signed [31:0] velocity_divergence;

  modport source (
    output valid, sound_speed, smoothing_length, old_coeff, velocity_divergence,
    input  ready
  );
  modport sink (
    input  valid, sound_speed, smoothing_length, old_coeff, velocity_divergence,
    output ready
  );
endinterface

interface svs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] new_coeff;

  modport source (
    output valid, new_coeff,
    input  ready
  );
  modport sink (
    input  valid, new_coeff,
    output ready
  );
endinterface

FILE: sv/svs_front.sv
// ----------------------------------------------------------------------------
// svs_front: numerator and divisor pipeline
// Forms N = A*H*2^32 + S*D*H*2^16 + D*C*G*M and Dn = H*2^32 + D*C*G from
// 32x32 partial products over six stages, then checks for quotient overflow.
// ----------------------------------------------------------------------------
module svs_front import svs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  in_t               item_i,
  input  logic [DATA_W-1:0] time_step_i,
  input  logic [DATA_W-1:0] decay_i,
  input  logic [DATA_W-1:0] floor_i,
  output logic              valid_o,
  output div_t              div_o
);

  logic [6:0] v_q;

  logic [DATA_W-1:0]   src;
  logic [2*DATA_W-1:0] ah1_q, sd1_q, dc1_q;
  logic [DATA_W-1:0]   h1_q;

  logic [2*DATA_W-1:0] sdh_lo2_q, sdh_hi2_q, dcg_lo2_q, dcg_hi2_q, ah2_q;
  logic [DATA_W-1:0]   h2_q;

  logic [3*DATA_W-1:0] sdh3_q, dcg3_q;
  logic [2*DATA_W-1:0] ah3_q;
  logic [DATA_W-1:0]   h3_q;

  logic [2*DATA_W-1:0] m0_4_q, m1_4_q, m2_4_q;
  logic [112:0]        n4_q;
  logic [DEN_W-1:0]    den4_q;

  logic [4*DATA_W-1:0] dcgm5_q;
  logic [112:0]        n5_q;
  logic [DEN_W-1:0]    den5_q;

  logic [NUM_W-1:0]    num6_q;
  logic [DEN_W-1:0]    den6_q;

  logic                sat;
  div_t                div7_q;

  // Magnitude of a negative divergence; the most negative value maps to 2^31.
  assign src = item_i.velocity_divergence[DATA_W-1] ?
               (~item_i.velocity_divergence + 32'd1) : '0;

  assign sat = num6_q >= {den6_q, 32'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[5:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ah1_q <= item_i.old_coeff * item_i.smoothing_length;
      sd1_q <= src * time_step_i;
      dc1_q <= time_step_i * item_i.sound_speed;
      h1_q  <= item_i.smoothing_length;

      sdh_lo2_q <= sd1_q[DATA_W-1:0] * h1_q;
      sdh_hi2_q <= sd1_q[2*DATA_W-1:DATA_W] * h1_q;
      dcg_lo2_q <= dc1_q[DATA_W-1:0] * decay_i;
      dcg_hi2_q <= dc1_q[2*DATA_W-1:DATA_W] * decay_i;
      ah2_q     <= ah1_q;
      h2_q      <= h1_q;

      sdh3_q <= {32'b0, sdh_lo2_q} + {sdh_hi2_q, 32'b0};
      dcg3_q <= {32'b0, dcg_lo2_q} + {dcg_hi2_q, 32'b0};
      ah3_q  <= ah2_q;
      h3_q   <= h2_q;

      m0_4_q <= dcg3_q[DATA_W-1:0] * floor_i;
      m1_4_q <= dcg3_q[2*DATA_W-1:DATA_W] * floor_i;
      m2_4_q <= dcg3_q[3*DATA_W-1:2*DATA_W] * floor_i;
      n4_q   <= {17'b0, ah3_q, 32'b0} + {1'b0, sdh3_q, 16'b0};
      den4_q <= {33'b0, h3_q, 32'b0} + {1'b0, dcg3_q};

      dcgm5_q <= {64'b0, m0_4_q} + {32'b0, m1_4_q, 32'b0} + {m2_4_q, 64'b0};
      n5_q    <= n4_q;
      den5_q  <= den4_q;

      num6_q <= {16'b0, n5_q} + {1'b0, dcgm5_q};
      den6_q <= den5_q;

      // On overflow the remainder is cleared; the quotient is forced at the end.
      div7_q.sat <= sat;
      div7_q.rem <= sat ? '0 : num6_q;
      div7_q.den <= den6_q;
      div7_q.quo <= '0;
    end
  end

  assign valid_o = v_q[6];
  assign div_o   = div7_q;

endmodule

FILE: sv/svs_div_cell.sv
// ----------------------------------------------------------------------------
// svs_div_cell: one restoring division step
// Compares the remainder with the divisor shifted to the top quotient bit,
// subtracts when it fits, shifts the remainder left and appends the bit.
// ----------------------------------------------------------------------------
module svs_div_cell import svs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  div_t div_i,
  output logic valid_o,
  output div_t div_o
);

  logic             valid_q;
  div_t             div_q, div_d;
  logic [NUM_W-1:0] dsh;
  logic [NUM_W-1:0] diff;
  logic [NUM_W-1:0] kept;
  logic             ge;

  // The remainder stays below den * 2^32, so den * 2^31 is the step divisor.
  assign dsh  = {1'b0, div_i.den, 31'b0};
  assign ge   = div_i.rem >= dsh;
  assign diff = div_i.rem - dsh;
  assign kept = ge ? diff : div_i.rem;

  always_comb begin
    div_d     = div_i;
    div_d.rem = {kept[NUM_W-2:0], 1'b0};
    div_d.quo = {div_i.quo[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule

FILE: sv/sph_viscosity_switch_update.sv
// ----------------------------------------------------------------------------
// sph_viscosity_switch_update: artificial viscosity switch, implicit step
// Updates one particle's viscosity coefficient per transaction.
// ----------------------------------------------------------------------------
// Items arrive on in_i (sound speed, smoothing length, old coefficient and
// signed velocity divergence) and leave on out_o as the new coefficient.
// Registers time_step, decay_constant, coeff_floor and coeff_ceiling are
// written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user must write them
// only while the block is idle, which the block itself does not enforce.
// Seven stages of 32x32 partial products and wide adds build the numerator
// and divisor and check for quotient overflow, a chain of 32 division cells
// produces one quotient bit each, and a final register applies overflow
// saturation and the ceiling clamp. While no result waits on a stalled
// receiver, one transaction is accepted per cycle, and up to 40 are in flight.
//
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_i.ready drops; it rises again in the cycle the result is taken.
// Reset empties the pipeline and loads the register reset values.
// ----------------------------------------------------------------------------
module sph_viscosity_switch_update import svs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  svs_in_if.sink               in_i,
  svs_out_if.source            out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_wdata_i
);

  logic [DATA_W-1:0] time_step_q, decay_q, floor_q, ceil_q;

  logic              pipe_en;
  in_t               item;
  logic [QUO_W:0]    cell_valid;
  div_t              cell_div [QUO_W+1];

  logic              out_valid_q;
  logic [DATA_W-1:0] out_coeff_q;
  logic [DATA_W-1:0] quo_fin;
  logic [DATA_W-1:0] coeff_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= RST_TIME_STEP;
      decay_q     <= RST_DECAY_CONSTANT;
      floor_q     <= RST_COEFF_FLOOR;
      ceil_q      <= RST_COEFF_CEILING;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TIME_STEP:      time_step_q <= cfg_wdata_i;
        CFG_DECAY_CONSTANT: decay_q     <= cfg_wdata_i;
        CFG_COEFF_FLOOR:    floor_q     <= cfg_wdata_i;
        CFG_COEFF_CEILING:  ceil_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign pipe_en    = !out_valid_q || out_o.ready;
  assign in_i.ready = pipe_en;

  assign item.sound_speed         = in_i.sound_speed;
  assign item.smoothing_length    = in_i.smoothing_length;
  assign item.old_coeff           = in_i.old_coeff;
  assign item.velocity_divergence = in_i.velocity_divergence;

  svs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (pipe_en),
    .valid_i    (in_i.valid),
    .item_i     (item),
    .time_step_i(time_step_q),
    .decay_i    (decay_q),
    .floor_i    (floor_q),
    .valid_o    (cell_valid[0]),
    .div_o      (cell_div[0])
  );

  for (genvar k = 0; k < QUO_W; k++) begin : g_cell
    svs_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (pipe_en),
      .valid_i(cell_valid[k]),
      .div_i  (cell_div[k]),
      .valid_o(cell_valid[k+1]),
      .div_o  (cell_div[k+1])
    );
  end

  assign quo_fin = cell_div[QUO_W].sat ? '1 : cell_div[QUO_W].quo;
  assign coeff_d = (quo_fin > ceil_q) ? ceil_q : quo_fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      out_valid_q <= cell_valid[QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      out_coeff_q <= coeff_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.new_coeff = out_coeff_q;

  // A finished division reaches the output register on the next advancing edge.
  a_chain_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pipe_en && cell_valid[QUO_W]) |=> out_valid_q)
    else $error("finished division did not reach the output register");

  // An overflowing quotient always leaves as the ceiling.
  a_sat_ceiling: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pipe_en && cell_valid[QUO_W] && cell_div[QUO_W].sat)
      |=> (out_o.new_coeff == $past(ceil_q)))
    else $error("saturated quotient not clamped to the ceiling");

  // A stall freezes every stage of the chain.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(cell_valid))
    else $error("division chain moved during a stall");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of sph_viscosity_switch_update
// Streams particle items through the viscosity switch update and predicts
// each new coefficient with exact wide-integer arithmetic. Directed tests
// cover reset values, unused register indexes, field extremes, zero smoothing
// length, quotient saturation and the ceiling clamp. Random phases then run
// under changing register settings, later ones with random gaps per channel.
// ----------------------------------------------------------------------------
module tb;
  import svs_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 300000;
  localparam int unsigned DRAIN_CYCLES    = 60;
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned ITEMS_PER_PHASE = 118;

  localparam logic [DATA_W-1:0] ONE_Q16  = 32'h0001_0000;
  localparam logic [DATA_W-1:0] ALL_ONES = '1;
  localparam logic [DATA_W-1:0] MOST_NEG = 32'h8000_0000;
  localparam logic [DATA_W-1:0] MOST_POS = 32'h7FFF_FFFF;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [DATA_W-1:0]    cfg_wdata;

  svs_in_if  in_if ();
  svs_out_if out_if ();

  sph_viscosity_switch_update u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Register contents as the block should hold them.
  logic [DATA_W-1:0] time_step_q      = RST_TIME_STEP;
  logic [DATA_W-1:0] decay_constant_q = RST_DECAY_CONSTANT;
  logic [DATA_W-1:0] coeff_floor_q    = RST_COEFF_FLOOR;
  logic [DATA_W-1:0] coeff_ceiling_q  = RST_COEFF_CEILING;

  logic [DATA_W-1:0] pending_coeffs[$];
  int unsigned fail_count    = 0;
  int unsigned checked_count = 0;
  int unsigned setting_count = 0;
  int unsigned cycle_count   = 0;
  bit          sender_throttle = 1'b0;
  bit          sink_throttle   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // One implicit-Euler step: numerator and divisor are both scaled by h so
  // that a single exact division gives the floored Q16.16 coefficient.
  function automatic logic [DATA_W-1:0] predict_coeff(input logic [DATA_W-1:0] cs,
                                                      input logic [DATA_W-1:0] h,
                                                      input logic [DATA_W-1:0] alpha,
                                                      input logic [DATA_W-1:0] divv);
    logic [191:0] source_mag;
    logic [191:0] decay_prod;
    logic [191:0] numer;
    logic [191:0] denom;
    logic [191:0] quot;
    logic [DATA_W-1:0] coeff;
    source_mag = divv[DATA_W-1] ? 192'(DATA_W'(~divv + 1'b1)) : '0;
    decay_prod = 192'(time_step_q) * 192'(cs) * 192'(decay_constant_q);
    numer = ((192'(alpha) * 192'(h)) << 32)
          + ((source_mag * 192'(time_step_q) * 192'(h)) << 16)
          + decay_prod * 192'(coeff_floor_q);
    denom = (192'(h) << 32) + decay_prod;
    if (denom == '0) begin
      coeff = ALL_ONES;
    end else begin
      quot  = numer / denom;
      coeff = (quot > 192'(ALL_ONES)) ? ALL_ONES : quot[DATA_W-1:0];
    end
    return (coeff > coeff_ceiling_q) ? coeff_ceiling_q : coeff;
  endfunction

  // Mostly back-to-back, sometimes a few cycles, now and then a long gap.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [DATA_W-1:0] pick_field(input logic [DATA_W-1:0] typical_max);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(0, typical_max);
    if (r < 85) return $urandom();
    if (r < 92) return '0;
    return ALL_ONES;
  endfunction

  function automatic logic [DATA_W-1:0] pick_divergence();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return DATA_W'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
    if (r < 85) return $urandom();
    if (r < 90) return MOST_NEG;
    if (r < 95) return MOST_POS;
    return ALL_ONES;
  endfunction

  function automatic logic [DATA_W-1:0] pick_setting(input logic [DATA_W-1:0] typical_max);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 25) return ALL_ONES;
    if (r < 40) return $urandom();
    return $urandom_range(0, typical_max);
  endfunction

  task automatic send_particle(input logic [DATA_W-1:0] cs,
                               input logic [DATA_W-1:0] h,
                               input logic [DATA_W-1:0] alpha,
                               input logic [DATA_W-1:0] divv);
    int unsigned gap;
    gap = sender_throttle ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
    @(negedge clk);
    in_if.valid               <= 1'b1;
    in_if.sound_speed         <= cs;
    in_if.smoothing_length    <= h;
    in_if.old_coeff           <= alpha;
    in_if.velocity_divergence <= divv;
    do @(posedge clk); while (!in_if.ready);
    pending_coeffs.push_back(predict_coeff(cs, h, alpha, divv));
  endtask

  // Stops the input stream and waits until every outstanding result is back.
  task automatic wait_idle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_coeffs.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TIME_STEP:      time_step_q      = value;
      CFG_DECAY_CONSTANT: decay_constant_q = value;
      CFG_COEFF_FLOOR:    coeff_floor_q    = value;
      CFG_COEFF_CEILING:  coeff_ceiling_q  = value;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [DATA_W-1:0] dt,
                               input logic [DATA_W-1:0] sigma,
                               input logic [DATA_W-1:0] floor_val,
                               input logic [DATA_W-1:0] ceiling_val);
    wait_idle();
    write_register(CFG_TIME_STEP, dt);
    write_register(CFG_DECAY_CONSTANT, sigma);
    write_register(CFG_COEFF_FLOOR, floor_val);
    write_register(CFG_COEFF_CEILING, ceiling_val);
    setting_count++;
  endtask

  // With a zero time step the coefficient only passes through the clamp.
  task automatic test_reset_defaults();
    sender_throttle = 1'b0;
    sink_throttle   = 1'b0;
    send_particle(ONE_Q16, ONE_Q16, 32'h0000_8000, '0);
    send_particle(ALL_ONES, 32'd1, ALL_ONES, MOST_NEG);
    send_particle('0, ALL_ONES, '0, ALL_ONES);
    // Zero smoothing length and zero decay product: the divisor vanishes.
    send_particle(32'd12345, '0, 32'd100, MOST_POS);
    wait_idle();
  endtask

  task automatic test_unused_index();
    wait_idle();
    for (int i = CFG_COEFF_CEILING + 1; i < (1 << CFG_IDX_W); i++) begin
      write_register(CFG_IDX_W'(i), $urandom());
    end
    send_particle(ONE_Q16, ONE_Q16, 32'h0000_4000, '0);
    send_particle(ONE_Q16, 32'd1, ALL_ONES, '0);
    wait_idle();
  endtask

  task automatic test_field_extremes();
    apply_setting(32'd655, 32'd13107, 32'd6554, 32'h0002_0000);
    sender_throttle = 1'b1;
    sink_throttle   = 1'b1;
    send_particle('0, 32'd1, '0, '0);
    send_particle(ALL_ONES, ALL_ONES, ALL_ONES, MOST_POS);
    send_particle(32'h0002_0000, 32'h0000_8000, 32'h0000_C000, MOST_NEG);
    send_particle(32'h0001_8000, 32'h0000_4000, 32'h0000_C000, ALL_ONES);
    // Zero smoothing length with a nonzero decay product.
    send_particle(ONE_Q16, '0, ONE_Q16, 32'hFFFE_0000);
    send_particle(ALL_ONES, 32'd1, ONE_Q16, '0);
    send_particle(ONE_Q16, 32'd1, ALL_ONES, MOST_NEG);
    send_particle(32'h0001_8000, 32'h0000_4000, 32'h0000_C000, 32'hFFFE_0000);
    wait_idle();
  endtask

  task automatic test_saturation();
    apply_setting(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    send_particle('0, ALL_ONES, ALL_ONES, MOST_NEG);
    send_particle(ALL_ONES, 32'd1, '0, '0);
    send_particle('0, '0, 32'd5, '0);
    // A zero ceiling forces every result to zero.
    apply_setting('0, '0, '0, '0);
    send_particle(ONE_Q16, ONE_Q16, ONE_Q16, 32'hFFFF_0000);
    send_particle('0, '0, ALL_ONES, MOST_NEG);
    send_particle(ALL_ONES, ALL_ONES, ALL_ONES, MOST_POS);
    wait_idle();
  endtask

  task automatic test_random_settings();
    logic [DATA_W-1:0] h;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      apply_setting(pick_setting(32'h0000_1000), pick_setting(32'h0002_0000),
                    pick_setting(32'h0001_0000), pick_setting(32'h0004_0000));
      sender_throttle = (phase != 0) && ($urandom_range(0, 3) != 0);
      sink_throttle   = (phase != 0) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Halfway through, let the pipeline run dry before going on.
        if (n == ITEMS_PER_PHASE / 2) wait_idle();
        h = pick_field(32'h0002_0000);
        if (h == '0) h = 32'd1;
        send_particle(pick_field(32'h0004_0000), h, pick_field(32'h0002_0000),
                      pick_divergence());
      end
    end
    wait_idle();
  endtask

  initial begin : result_sink
    int unsigned stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        stall_left = sink_throttle ? pick_gap() : 0;
        out_if.ready <= (stall_left == 0);
        if (stall_left != 0) stall_left--;
      end
    end
  end

  always @(posedge clk) begin : coeff_check
    logic [DATA_W-1:0] want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_coeffs.size() == 0) begin
        $error("new_coeff %h arrived with no transaction outstanding", out_if.new_coeff);
        fail_count++;
      end else begin
        want = pending_coeffs.pop_front();
        checked_count++;
        if (out_if.new_coeff !== want) begin
          $error("new_coeff mismatch: expected %h, actual %h", want, out_if.new_coeff);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_n                     = 1'b0;
    cfg_we                    = 1'b0;
    cfg_idx                   = '0;
    cfg_wdata                 = '0;
    in_if.valid               = 1'b0;
    in_if.sound_speed         = '0;
    in_if.smoothing_length    = '0;
    in_if.old_coeff           = '0;
    in_if.velocity_divergence = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_unused_index();
    test_field_extremes();
    test_saturation();
    test_random_settings();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb: %0d coefficient updates checked under reset values and %0d register settings,",
             checked_count, setting_count);
    $display("tb: including saturation, ceiling clamp, zero smoothing length and unused indexes");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/svs_pkg.sv
sv/svs_if.sv
sv/svs_front.sv
sv/svs_div_cell.sv
sv/sph_viscosity_switch_update.sv
tb/tb.sv
